// ----- rtl/efti_pkg.sv -----
// Package for the escape-time fractal iterator: widths, register codes,
// shared types and the Q4.28 saturation helper. No dependencies.
`default_nettype none

package efti_pkg;

   localparam int Q_W        = 32;              // Q4.28 coordinate width
   localparam int FRAC_W     = 28;              // fraction bits
   localparam int PIX_W      = 10;              // pixel index width
   localparam int STEP_W     = 29;              // step register width
   localparam int CNT_W      = 16;              // iteration counter width
   localparam int MAX_DIM    = 1024;            // pixels per axis
   localparam int PROD_W     = 2 * Q_W;         // Q8.56 product width
   localparam int SAT_W      = PIX_W + STEP_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Q_DEPTH    = 2;               // front-to-back queue entries
   localparam int PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int LVL_W      = $clog2(Q_DEPTH + 1);

   // 4.0 in Q8.56
   localparam logic [PROD_W-1:0] FOUR_Q56 = PROD_W'(1) << (2 * FRAC_W + 2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE     = 3'd0,
      CSR_LOWER_X  = 3'd1,
      CSR_LOWER_Y  = 3'd2,
      CSR_STEP     = 3'd3,
      CSR_JULIA_RE = 3'd4,
      CSR_JULIA_IM = 3'd5,
      CSR_MAX_ITER = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_ADD
   } back_state_type;

   typedef struct packed {
      logic                    mode;     // 1 selects Julia
      logic signed [Q_W-1:0]   lower_x;
      logic signed [Q_W-1:0]   lower_y;
      logic [STEP_W-1:0]       step;
      logic signed [Q_W-1:0]   julia_re;
      logic signed [Q_W-1:0]   julia_im;
      logic [CNT_W-1:0]        max_iter;
   } cfg_type;

   typedef struct packed {
      logic signed [Q_W-1:0] re;
      logic signed [Q_W-1:0] im;
      logic signed [Q_W-1:0] cre;
      logic signed [Q_W-1:0] cim;
   } point_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             full;
      logic             empty;
   } queue_status_type;

   // Clamp a wide signed value into the Q4.28 range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-Q_W:0] top_bits;
      top_bits = v[SAT_W-1:Q_W-1];
      if ((&top_bits) || (~|top_bits)) begin
         return v[Q_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         return {1'b0, {(Q_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/escape_time_fractal_iterator_top.sv -----
// Top level of the escape-time fractal iterator: configuration registers,
// front end, point queue and iteration back end. Depends on efti_pkg, efti_front, efti_queue and efti_back.
`default_nettype none

// Each transfer on req_ names one pixel by row and column; the block returns
// one transfer on rsp_ with the Mandelbrot (mode 0) or Julia (mode 1)
// escape-time count in signed Q4.28 arithmetic. The front end registers the
// start point and parks it in a two-entry queue, so up to three pixels can be
// taken in while one iterates. The back end runs each iteration as a BK_MUL
// state (three 32x32 products) then a BK_ADD state (escape test and update);
// that iteration loop sets the throughput. A finished count waits in the
// output register and the back end can already start the next pixel. Write
// configuration only while idle.
module escape_time_fractal_iterator_top
   import efti_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,   // [9:0] pixel_row, [19:10] pixel_col
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] iteration_count
   // register writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              pt_valid, pt_ready;
   point_type         pt;
   logic              q_valid, q_ready;
   point_type         q_data;
   queue_status_type  q_status;
   logic [CNT_W-1:0]  rsp_count;

   // Register file: ignore writes to indexes beyond the list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:     cfg_in.mode     = csr_wdata[0];
            CSR_LOWER_X:  cfg_in.lower_x  = csr_wdata[Q_W-1:0];
            CSR_LOWER_Y:  cfg_in.lower_y  = csr_wdata[Q_W-1:0];
            CSR_STEP:     cfg_in.step     = csr_wdata[STEP_W-1:0];
            CSR_JULIA_RE: cfg_in.julia_re = csr_wdata[Q_W-1:0];
            CSR_JULIA_IM: cfg_in.julia_im = csr_wdata[Q_W-1:0];
            CSR_MAX_ITER: cfg_in.max_iter = csr_wdata[CNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode     <= 1'b0;
         cfg_ff.lower_x  <= 32'shE000_0000;   // -2.0
         cfg_ff.lower_y  <= 32'shE000_0000;   // -2.0
         cfg_ff.step     <= 29'h010_0000;     // 1/256
         cfg_ff.julia_re <= '0;
         cfg_ff.julia_im <= '0;
         cfg_ff.max_iter <= 16'd255;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Form the start point
   efti_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_row   (req_tdata[PIX_W-1:0]),
      .in_col   (req_tdata[2*PIX_W-1:PIX_W]),
      .pt_valid (pt_valid),
      .pt_ready (pt_ready),
      .pt       (pt)
   );

   // Decouple point setup from iteration
   efti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pt_valid),
      .in_ready  (pt_ready),
      .in_data   (pt),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data),
      .status    (q_status)
   );

   // Iterate and hold the count until transfer
   efti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .max_iter  (cfg_ff.max_iter),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_count (rsp_count)
   );

   assign rsp_tdata = rsp_count;

   // Drop any pending response at reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A count never passes the iteration limit
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= cfg_ff.max_iter))
      else $error("iteration count above limit");

   // Queue occupancy stays within its depth
   a_q_level: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= LVL_W'(Q_DEPTH))
      else $error("queue overflow");

   a_q_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty at once");

endmodule

`default_nettype wire

// ----- rtl/efti_front.sv -----
// Front end: accepts a pixel, forms its Q4.28 start point and constant.
// Depends on efti_pkg.
`default_nettype none

module efti_front
   import efti_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [PIX_W-1:0] in_row,
   input  wire logic [PIX_W-1:0] in_col,
   output logic                  pt_valid,
   input  wire logic             pt_ready,
   output point_type             pt
);

   logic                          pt_valid_ff, pt_valid_in;
   point_type                     pt_ff, pt_in;
   logic [PIX_W-1:0]              row_cl, col_cl;
   logic [PIX_W+STEP_W-1:0]       off_x, off_y;
   logic signed [SAT_W-1:0]       sum_x, sum_y;

   always_comb begin
      row_cl = in_row;
      col_cl = in_col;
      if (32'(in_row) > MAX_DIM - 1) begin
         row_cl = PIX_W'(MAX_DIM - 1);
      end
      if (32'(in_col) > MAX_DIM - 1) begin
         col_cl = PIX_W'(MAX_DIM - 1);
      end
      off_x = row_cl * cfg.step;
      off_y = col_cl * cfg.step;
      sum_x = {{(SAT_W-Q_W){cfg.lower_x[Q_W-1]}}, cfg.lower_x}
              + $signed({2'b00, off_x});
      sum_y = {{(SAT_W-Q_W){cfg.lower_y[Q_W-1]}}, cfg.lower_y}
              + $signed({2'b00, off_y});
      pt_in.re = sat_q(sum_x);
      pt_in.im = sat_q(sum_y);
      if (cfg.mode) begin
         pt_in.cre = cfg.julia_re;
         pt_in.cim = cfg.julia_im;
      end else begin
         pt_in.cre = pt_in.re;
         pt_in.cim = pt_in.im;
      end
   end

   assign in_ready = !pt_valid_ff || pt_ready;

   always_comb begin
      pt_valid_in = pt_valid_ff && !pt_ready;
      if (in_valid && in_ready) begin
         pt_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= 1'b0;
      end else begin
         pt_valid_ff <= pt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pt_ff <= pt_in;
      end
   end

   assign pt_valid = pt_valid_ff;
   assign pt       = pt_ff;

endmodule

`default_nettype wire

// ----- rtl/efti_queue.sv -----
// Short queue of start points between front and back end.
// Depends on efti_pkg.
`default_nettype none

module efti_queue
   import efti_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire point_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output point_type      out_data,
   output queue_status_type status
);

   point_type          mem_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic               push, pop;

   assign in_ready  = (level_ff != LVL_W'(Q_DEPTH));
   assign out_valid = (level_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assign status.level = level_ff;
   assign status.full  = !in_ready;
   assign status.empty = !out_valid;

endmodule

`default_nettype wire

// ----- rtl/efti_back.sv -----
// Back end: iterates z = z*z + c on one point and holds the count for output.
// Depends on efti_pkg.
`default_nettype none

module efti_back
   import efti_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] max_iter,
   input  wire logic             q_valid,
   output logic                  q_ready,
   input  wire point_type        q_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [CNT_W-1:0]      rsp_count
);

   back_state_type             state_ff, state_in;
   logic signed [Q_W-1:0]      re_ff, re_in, im_ff, im_in;
   logic signed [Q_W-1:0]      cre_ff, cre_in, cim_ff, cim_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [PROD_W-1:0]   rr_ff, ii_ff, ri_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]           out_cnt_ff, out_cnt_in;
   logic [PROD_W-1:0]          mag;
   logic signed [PROD_W-1:0]   diff;
   logic signed [SAT_W-1:0]    nre, nim;
   logic                       done, out_free;

   always_comb begin
      mag  = PROD_W'(rr_ff) + PROD_W'(ii_ff);
      diff = rr_ff - ii_ff;
      // arithmetic shifts floor toward minus infinity
      nre  = SAT_W'(diff >>> FRAC_W)
             + {{(SAT_W-Q_W){cre_ff[Q_W-1]}}, cre_ff};
      nim  = SAT_W'(ri_ff >>> (FRAC_W - 1))
             + {{(SAT_W-Q_W){cim_ff[Q_W-1]}}, cim_ff};
      done = (mag >= FOUR_Q56) || (cnt_ff >= max_iter);
      out_free = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_cnt_in   = out_cnt_ff;
      q_ready      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               re_in    = q_data.re;
               im_in    = q_data.im;
               cre_in   = q_data.cre;
               cim_in   = q_data.cim;
               cnt_in   = '0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_ADD;
         end
         BK_ADD: begin
            if (done) begin
               // hold here until the output register frees up
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_cnt_in   = cnt_ff;
                  state_in     = BK_IDLE;
               end
            end else begin
               re_in    = sat_q(nre);
               im_in    = sat_q(nim);
               cnt_in   = cnt_ff + 1'b1;
               state_in = BK_MUL;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff      <= re_in;
      im_ff      <= im_in;
      cre_ff     <= cre_in;
      cim_ff     <= cim_in;
      cnt_ff     <= cnt_in;
      out_cnt_ff <= out_cnt_in;
      rr_ff      <= re_ff * re_ff;
      ii_ff      <= im_ff * im_ff;
      ri_ff      <= re_ff * im_ff;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_count = out_cnt_ff;

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking bench for escape_time_fractal_iterator_top: drives pixel transfers,
// predicts each escape count in Q4.28 and compares it with the returned count.
// Depends on efti_pkg and the top-level RTL only.
`default_nettype none

module tb;
   import efti_pkg::*;

   localparam int HOLD_OFF_CYCLES = 400;        // long receiver stall to fill the block
   localparam int DRAIN_CYCLES    = 16;         // settle time after the last count
   // Slowest pixel iterates 65535 times; the watchdog limit leaves room for that.
   localparam int IDLE_LIMIT      = 600000;
   localparam int RANDOM_PHASES   = 16;
   localparam int PHASE_PIXELS    = 100;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;   // no register behind it
   localparam logic [63:0] RADIUS_SQ_Q56 = 64'd1 << 58;    // 4.0 in Q8.56
   localparam longint Q_LOW  = -64'sd2147483648;
   localparam longint Q_HIGH = 64'sd2147483647;

   // Handy Q4.28 values
   localparam logic [31:0] MINUS_TWO   = 32'hE000_0000;
   localparam logic [31:0] Q_MAX_WORD  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN_WORD  = 32'h8000_0000;
   localparam logic [31:0] STEP_1_256  = 32'd1048576;
   localparam logic [31:0] JULIA_C_RE  = -32'sd214748365;  // -0.8
   localparam logic [31:0] JULIA_C_IM  = 32'sd41875931;    // 0.156

   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_RARE
   } stall_style_type;

   typedef struct {
      logic [PIX_W-1:0] row;
      logic [PIX_W-1:0] col;
      logic [CNT_W-1:0] count;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // [9:0] pixel_row, [19:10] pixel_col
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [15:0]           rsp_tdata;   // [15:0] iteration_count
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the register file, kept in step with every write
   logic                  shadow_julia;
   logic signed [Q_W-1:0] shadow_lower_x;
   logic signed [Q_W-1:0] shadow_lower_y;
   logic [STEP_W-1:0]     shadow_step;
   logic signed [Q_W-1:0] shadow_c_re;
   logic signed [Q_W-1:0] shadow_c_im;
   logic [CNT_W-1:0]      shadow_max_iter;

   pixel_result_type pending_counts[$];
   int  mismatch_count = 0;
   int  idle_cycles = 0;
   int  hold_off_len = 0;     // set by a test, consumed by the receiver
   bit  sender_gaps = 1'b1;
   int  burst_left = 0;

   escape_time_fractal_iterator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Escape-count predictor
   // ------------------------------------------------------------------

   function automatic longint clamp_q(input longint v);
      if (v < Q_LOW) return Q_LOW;
      if (v > Q_HIGH) return Q_HIGH;
      return v;
   endfunction

   // Iterate z = z*z + c from the pixel's point with the shadow registers.
   // Squares are exact in Q8.56; updates floor back to Q4.28 and clamp.
   function automatic logic [CNT_W-1:0] escape_count(input logic [PIX_W-1:0] row,
                                                     input logic [PIX_W-1:0] col);
      longint      re, im, c_re, c_im, re_sq, im_sq;
      logic [63:0] mag_sq;
      int unsigned steps;
      re = clamp_q(longint'(shadow_lower_x) + longint'(row) * longint'(shadow_step));
      im = clamp_q(longint'(shadow_lower_y) + longint'(col) * longint'(shadow_step));
      if (shadow_julia) begin
         c_re = longint'(shadow_c_re);
         c_im = longint'(shadow_c_im);
      end else begin
         c_re = re;
         c_im = im;
      end
      steps = 0;
      while (steps < shadow_max_iter) begin
         re_sq  = re * re;
         im_sq  = im * im;
         mag_sq = re_sq + im_sq;          // up to 2^63, read as unsigned
         if (mag_sq >= RADIUS_SQ_Q56) break;
         // compute both parts from the old z before replacing it
         c_re = c_re;                     // constant across steps
         im   = clamp_q(((re * im) >>> 27) + c_im);
         re   = clamp_q(((re_sq - im_sq) >>> 28) + c_re);
         steps++;
      end
      return steps[CNT_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting, result checking, watchdog
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Compare every count transfer with the oldest outstanding prediction.
   always @(posedge clock) begin : check_counts
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            report_mismatch($sformatf("count %0d returned with no pixel outstanding",
                                      rsp_tdata));
         end else begin
            want = pending_counts.pop_front();
            if (rsp_tdata[CNT_W-1:0] !== want.count) begin
               report_mismatch($sformatf("pixel (%0d,%0d): count %0d, predicted %0d",
                                         want.row, want.col, rsp_tdata, want.count));
            end
         end
      end
   end

   // Abort when neither side moves a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: ready pattern changes style every so often; a requested
   // hold-off drops ready for a long stretch counted here.
   // ------------------------------------------------------------------

   initial begin : receiver
      stall_style_type style;
      int              style_left;
      int              tick;
      int              hold;
      rsp_tready = 1'b0;
      style      = STALL_NONE;
      style_left = 0;
      tick       = 0;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            hold = hold_off_len;
            hold_off_len = 0;
            rsp_tready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
         end
         style_left--;
         tick++;
         case (style)
            STALL_NONE:     rsp_tready = 1'b1;
            STALL_COIN:     rsp_tready = 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_tready = (tick % 5) >= 2;
            default:        rsp_tready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sender side. All tasks start and end at a falling edge.
   // ------------------------------------------------------------------

   // Offer one pixel; predict its count and queue it once the transfer happens.
   task automatic send_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
      pixel_result_type item;
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      item.row   = row;
      item.col   = col;
      item.count = escape_count(row, col);
      req_tdata  = {4'b0, col, row};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pending_counts.push_back(item);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_random_pixel();
      send_pixel(PIX_W'($urandom_range(0, MAX_DIM - 1)),
                 PIX_W'($urandom_range(0, MAX_DIM - 1)));
   endtask

   // Stop offering and hold until every predicted count has come back.
   task automatic await_results();
      req_tvalid = 1'b0;
      while (pending_counts.size() != 0) @(negedge clock);
   endtask

   // Write one register and mirror it; only called while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         CSR_MODE:     shadow_julia    = value[0];
         CSR_LOWER_X:  shadow_lower_x  = value;
         CSR_LOWER_Y:  shadow_lower_y  = value;
         CSR_STEP:     shadow_step     = value[STEP_W-1:0];
         CSR_JULIA_RE: shadow_c_re     = value;
         CSR_JULIA_IM: shadow_c_im     = value;
         CSR_MAX_ITER: shadow_max_iter = value[CNT_W-1:0];
         default: ;   // unmapped index: the block ignores it
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all_csrs(input logic julia, input logic [31:0] lower_x,
                                 input logic [31:0] lower_y, input logic [31:0] step,
                                 input logic [31:0] c_re, input logic [31:0] c_im,
                                 input logic [31:0] max_iter);
      write_csr(CSR_MODE, {31'b0, julia});
      write_csr(CSR_LOWER_X, lower_x);
      write_csr(CSR_LOWER_Y, lower_y);
      write_csr(CSR_STEP, step);
      write_csr(CSR_JULIA_RE, c_re);
      write_csr(CSR_JULIA_IM, c_im);
      write_csr(CSR_MAX_ITER, max_iter);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset registers: lower corner -2-2i, step 1/256, so pixel 512 sits on zero.
   task automatic check_reset_values();
      send_pixel(10'd512, 10'd512);    // origin never escapes: full limit of 255
      send_pixel(10'd256, 10'd512);    // -1 cycles between -1 and 0
      send_pixel(10'd0, 10'd0);        // corner: escapes before any update
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      await_results();
   endtask

   task automatic check_iteration_limits();
      write_csr(CSR_MAX_ITER, 32'd0);  // zero limit: no update, count zero
      send_pixel(10'd512, 10'd512);
      await_results();
      write_csr(CSR_MAX_ITER, 32'd1);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd384, 10'd384);    // -0.5-0.5i takes exactly one update
      await_results();
      write_csr(CSR_MAX_ITER, 32'h0000_FFFF);   // widest limit, one pixel only
      send_pixel(10'd512, 10'd512);
      await_results();
      write_csr(CSR_MAX_ITER, 32'd255);
   endtask

   // Start points that land outside Q4.28 clamp and escape at once; a zero step pins every pixel to the corner.
   task automatic check_start_saturation();
      write_csr(CSR_LOWER_X, Q_MAX_WORD);
      write_csr(CSR_STEP, 32'hFFFF_FFFF);       // step above 1.0, upper bits dropped
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd512);
      await_results();
      write_csr(CSR_LOWER_X, Q_MIN_WORD);
      write_csr(CSR_LOWER_Y, Q_MIN_WORD);
      send_pixel(10'd1023, 10'd1023);           // -8 plus a huge offset clamps high
      await_results();
      write_csr(CSR_STEP, 32'd0);               // zero step: every pixel is the corner
      send_pixel(10'd1023, 10'd1023);
      await_results();
      write_csr(CSR_LOWER_X, 32'd0);
      write_csr(CSR_LOWER_Y, Q_MAX_WORD);
      send_pixel(10'd700, 10'd300);
      await_results();
      write_csr(CSR_LOWER_Y, 32'd0);
      send_pixel(10'd1023, 10'd1023);           // origin again through the zero step
      await_results();
   endtask

   task automatic check_julia_constant();
      write_all_csrs(1'b1, MINUS_TWO, MINUS_TWO, STEP_1_256, 32'd0, 32'd0, 32'd255);
      send_pixel(10'd512, 10'd512);    // c = 0, z = 0 stays put
      send_pixel(10'd576, 10'd512);    // z = 0.25 shrinks toward zero
      await_results();
      write_csr(CSR_JULIA_RE, Q_MAX_WORD);      // update clamps high, then escapes
      send_pixel(10'd512, 10'd512);
      await_results();
      write_csr(CSR_JULIA_RE, Q_MIN_WORD);
      write_csr(CSR_JULIA_IM, Q_MAX_WORD);
      send_pixel(10'd512, 10'd512);
      await_results();
      write_csr(CSR_JULIA_RE, JULIA_C_RE);
      write_csr(CSR_JULIA_IM, JULIA_C_IM);
      send_pixel(10'd400, 10'd560);
      send_pixel(10'd600, 10'd470);
      await_results();
   endtask

   // A write to the unmapped index must leave every register alone.
   task automatic check_unmapped_index();
      write_csr(CSR_UNMAPPED, 32'hFFFF_FFFF);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd450, 10'd540);
      await_results();
      write_csr(CSR_MODE, 32'd0);
   endtask

   // Stall the receiver long enough that the block fills and drops req_tready.
   task automatic check_stalled_output();
      write_all_csrs(1'b0, MINUS_TWO, MINUS_TWO, STEP_1_256, 32'd0, 32'd0, 32'd12);
      sender_gaps  = 1'b0;
      hold_off_len = HOLD_OFF_CYCLES;
      repeat (40) send_random_pixel();
      await_results();
      sender_gaps = 1'b1;
   endtask

   // Mostly windows around the set boundary with modest limits; every eighth
   // phase uses raw register values to hit clamping and masked-off bits.
   task automatic randomize_region(input bit raw);
      logic [31:0] max_iter;
      if (raw) begin
         write_all_csrs(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                        $urandom, {16'($urandom), 16'($urandom_range(0, 300))});
         write_csr(CSR_MODE, $urandom);
      end else begin
         max_iter = ($urandom_range(0, 4) == 0) ? $urandom_range(49, 255)
                                                : $urandom_range(1, 48);
         write_all_csrs(1'($urandom_range(0, 1)),
                        32'($urandom_range(0, 805306368)) - 32'd671088640,
                        32'($urandom_range(0, 805306368)) - 32'd402653184,
                        $urandom_range(1 << 10, 1 << 20),
                        32'($urandom_range(0, 536870912)) - 32'd268435456,
                        32'($urandom_range(0, 536870912)) - 32'd268435456,
                        max_iter);
      end
      if ($urandom_range(0, 5) == 0) write_csr(CSR_UNMAPPED, $urandom);
   endtask

   task automatic check_random_pixels();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         await_results();
         randomize_region(phase % 8 == 7);
         sender_gaps = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            // now and then pause until the block has emptied
            if ($urandom_range(0, 49) == 0) await_results();
            send_random_pixel();
         end
      end
      sender_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_MODE;
      csr_wdata  = '0;
      shadow_julia    = 1'b0;
      shadow_lower_x  = MINUS_TWO;
      shadow_lower_y  = MINUS_TWO;
      shadow_step     = STEP_1_256[STEP_W-1:0];
      shadow_c_re     = '0;
      shadow_c_im     = '0;
      shadow_max_iter = 16'd255;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      check_reset_values();
      check_iteration_limits();
      check_start_saturation();
      check_julia_constant();
      check_unmapped_index();
      check_stalled_output();
      check_random_pixels();

      // drain, then give stray transfers a chance to show up
      await_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
